FILE: hw/rtl/fdlm_pkg.sv
// Shared types, widths and constants for the feedback delay line mix unit.
// No dependencies; every other file in hw/rtl refers to this package.

package fdlm_pkg;

  localparam int MAX_LEN    = 16384;
  localparam int ADDR_W     = $clog2(MAX_LEN);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int MOD_CNT_W  = (ADDR_W > 1) ? $clog2(ADDR_W) : 1;
  localparam int SMP_W      = 24;
  localparam int FB_W       = 16;
  localparam int MIX_W      = 17;
  localparam int CFG_LEN_W  = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int FBP_W      = FB_W + SMP_W;
  localparam int MIXP_W     = MIX_W + 1 + SMP_W;
  localparam int WIDE_W     = 44;
  localparam int FB_ROUND   = 16384;
  localparam int FB_SHIFT   = 15;
  localparam int MIX_ROUND  = 32768;
  localparam int MIX_SHIFT  = 16;
  localparam int OQ_DEPTH   = 8;
  localparam int OQ_PTR_W   = 3;
  localparam int OQ_CNT_W   = 4;

  localparam logic [MIX_W-1:0] MIX_ONE = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic signed [SMP_W-1:0] smp_t;

  typedef struct packed {
    logic  valid;
    addr_t wpos;
    addr_t pos;
    logic  same;
    smp_t  x;
  } issue_t;

  typedef struct packed {
    logic signed [FB_W-1:0] fb;
    logic [MIX_W-1:0]       mix;
  } coef_t;

  typedef struct packed {
    logic  we;
    addr_t addr;
    smp_t  data;
  } ram_wr_t;

  function automatic smp_t sat_smp(input logic signed [WIDE_W-1:0] v);
    smp_t r;
    if ((&v[WIDE_W-1:SMP_W-1]) || (~|v[WIDE_W-1:SMP_W-1])) begin
      r = v[SMP_W-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(SMP_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SMP_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/fdlm_ram.sv
// Sample store: one write port, two registered read ports, read-old on collision.
// Depends on fdlm_pkg.

module fdlm_ram (
  input  logic              clk,
  input  fdlm_pkg::ram_wr_t wr,
  input  fdlm_pkg::addr_t   raddr_a,
  input  fdlm_pkg::addr_t   raddr_b,
  output fdlm_pkg::smp_t    rdata_a,
  output fdlm_pkg::smp_t    rdata_b
);

  fdlm_pkg::smp_t mem [fdlm_pkg::MAX_LEN];
  fdlm_pkg::smp_t rd_a_r;
  fdlm_pkg::smp_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a_r <= mem[raddr_a];
    rd_b_r <= mem[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

FILE: hw/rtl/fdlm_ctrl.sv
// Configuration registers, ring position, position reduction after a length
// write and the clearing pass over the store. Depends on fdlm_pkg.

module fdlm_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fdlm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdlm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_accept,
  input  fdlm_pkg::smp_t                      in_sample,
  output logic                                issue_ready,
  output fdlm_pkg::issue_t                    issue,
  output fdlm_pkg::coef_t                     coef,
  output fdlm_pkg::ram_wr_t                   clr_wr
);

  logic signed [fdlm_pkg::FB_W-1:0] fb_r, fb_nxt;
  logic [fdlm_pkg::MIX_W-1:0]       mix_r, mix_nxt;
  logic [fdlm_pkg::LEN_W-1:0]       len_r, len_nxt;
  fdlm_pkg::addr_t                  pos_r, pos_nxt;
  logic                             clr_busy_r, clr_busy_nxt;
  fdlm_pkg::addr_t                  clr_addr_r, clr_addr_nxt;
  logic                             mod_busy_r, mod_busy_nxt;
  logic [fdlm_pkg::MOD_CNT_W-1:0]   mod_cnt_r, mod_cnt_nxt;
  fdlm_pkg::addr_t                  rem_r, rem_nxt;
  logic                             last_acc_r;

  logic                             cfg_acc;
  logic                             len_one;
  logic [fdlm_pkg::CFG_LEN_W-1:0]   len_field;
  logic [fdlm_pkg::LEN_W-1:0]       len_cfg;
  logic [fdlm_pkg::MIX_W-1:0]       mix_field;
  logic [fdlm_pkg::MIX_W-1:0]       mix_cfg;
  logic [fdlm_pkg::LEN_W-1:0]       pos_inc;
  logic [fdlm_pkg::LEN_W-1:0]       trial;
  fdlm_pkg::addr_t                  rem_step;
  fdlm_pkg::addr_t                  wpos;

  assign cfg_ready   = !mod_busy_r;
  assign cfg_acc     = cfg_valid && cfg_ready;
  assign len_one     = (len_r == fdlm_pkg::LEN_W'(1));
  assign issue_ready = !clr_busy_r && !mod_busy_r && !(len_one && last_acc_r);

  always_comb begin
    len_field = cfg_data[fdlm_pkg::CFG_LEN_W-1:0];
    if (len_field == '0) begin
      len_cfg = fdlm_pkg::LEN_W'(1);
    end else if (32'(len_field) > fdlm_pkg::MAX_LEN) begin
      len_cfg = fdlm_pkg::LEN_W'(fdlm_pkg::MAX_LEN);
    end else begin
      len_cfg = fdlm_pkg::LEN_W'(len_field);
    end
    mix_field = cfg_data[fdlm_pkg::MIX_W-1:0];
    mix_cfg   = (mix_field > fdlm_pkg::MIX_ONE) ? fdlm_pkg::MIX_ONE : mix_field;
  end

  always_comb begin
    pos_inc = fdlm_pkg::LEN_W'(pos_r) + fdlm_pkg::LEN_W'(1);
    wpos    = (pos_r == '0) ? fdlm_pkg::ADDR_W'(len_r - fdlm_pkg::LEN_W'(1))
                            : pos_r - fdlm_pkg::ADDR_W'(1);
    trial   = {rem_r, pos_r[mod_cnt_r]};
    rem_step = (trial >= len_r) ? fdlm_pkg::ADDR_W'(trial - len_r)
                                : fdlm_pkg::ADDR_W'(trial);
  end

  always_comb begin
    fb_nxt       = fb_r;
    mix_nxt      = mix_r;
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    mod_busy_nxt = mod_busy_r;
    mod_cnt_nxt  = mod_cnt_r;
    rem_nxt      = rem_r;

    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + fdlm_pkg::ADDR_W'(1);
      if (clr_addr_r == fdlm_pkg::ADDR_W'(fdlm_pkg::MAX_LEN - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end

    // reduce the position modulo the new length, one bit a cycle
    if (mod_busy_r) begin
      rem_nxt     = rem_step;
      mod_cnt_nxt = mod_cnt_r - fdlm_pkg::MOD_CNT_W'(1);
      if (mod_cnt_r == '0) begin
        pos_nxt      = rem_step;
        mod_busy_nxt = 1'b0;
      end
    end else if (cfg_acc) begin
      unique case (cfg_index)
        fdlm_pkg::REG_FEEDBACK: fb_nxt = cfg_data[fdlm_pkg::FB_W-1:0];
        fdlm_pkg::REG_MIX:      mix_nxt = mix_cfg;
        fdlm_pkg::REG_LENGTH: begin
          len_nxt      = len_cfg;
          mod_busy_nxt = 1'b1;
          mod_cnt_nxt  = fdlm_pkg::MOD_CNT_W'(fdlm_pkg::ADDR_W - 1);
          rem_nxt      = '0;
        end
        default: ;
      endcase
    end

    if (in_accept) begin
      pos_nxt = (pos_inc == len_r) ? '0 : fdlm_pkg::ADDR_W'(pos_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r       <= '0;
      mix_r      <= '0;
      len_r      <= fdlm_pkg::LEN_W'(fdlm_pkg::MAX_LEN);
      pos_r      <= '0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      mod_busy_r <= 1'b0;
      mod_cnt_r  <= '0;
      rem_r      <= '0;
      last_acc_r <= 1'b0;
    end else begin
      fb_r       <= fb_nxt;
      mix_r      <= mix_nxt;
      len_r      <= len_nxt;
      pos_r      <= pos_nxt;
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      mod_busy_r <= mod_busy_nxt;
      mod_cnt_r  <= mod_cnt_nxt;
      rem_r      <= rem_nxt;
      last_acc_r <= in_accept;
    end
  end

  always_comb begin
    issue.valid = in_accept;
    issue.wpos  = wpos;
    issue.pos   = pos_r;
    issue.same  = len_one;
    issue.x     = in_sample;
    coef.fb     = fb_r;
    coef.mix    = mix_r;
    clr_wr.we   = clr_busy_r;
    clr_wr.addr = clr_addr_r;
    clr_wr.data = '0;
  end

endmodule

FILE: hw/rtl/fdlm_dpath.sv
// Four-stage sample datapath: feedback multiply, store write-back with
// forwarding, dry/wet mix. Depends on fdlm_pkg; the store is fdlm_ram.

module fdlm_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  fdlm_pkg::issue_t  issue,
  input  fdlm_pkg::coef_t   coef,
  input  fdlm_pkg::smp_t    rd_w,
  input  fdlm_pkg::smp_t    rd_p,
  output fdlm_pkg::ram_wr_t dp_wr,
  output logic              push_valid,
  output fdlm_pkg::smp_t    push_data
);

  logic                                 v1_r, v2_r, v3_r, v4_r;
  fdlm_pkg::addr_t                      wpos1_r, pos1_r, wpos2_r, pos2_r, wpos3_r;
  logic                                 same1_r, same2_r, same3_r;
  fdlm_pkg::smp_t                       x1_r, x2_r, x3_r;
  logic signed [fdlm_pkg::FBP_W-1:0]    prod2_r;
  fdlm_pkg::smp_t                       dly2_r, dly3_r, new3_r;
  logic signed [fdlm_pkg::MIXP_W-1:0]   pa4_r, pb4_r;

  fdlm_pkg::smp_t                       old1, dly1, dly2, new2, wet3;
  logic signed [fdlm_pkg::FBP_W-1:0]    prod1, fbp;
  logic signed [fdlm_pkg::WIDE_W-1:0]   sum2, acc4;
  logic [fdlm_pkg::MIX_W-1:0]           dry_w;
  logic signed [fdlm_pkg::MIXP_W-1:0]   pa3, pb3;

  // stage 1: pick up writes the store read did not see
  always_comb begin
    old1  = (v3_r && (wpos3_r == wpos1_r)) ? new3_r : rd_w;
    dly1  = (v3_r && (wpos3_r == pos1_r)) ? new3_r : rd_p;
    prod1 = fdlm_pkg::FBP_W'(coef.fb) * fdlm_pkg::FBP_W'(old1);
  end

  // stage 2: round, add, saturate, write back
  always_comb begin
    fbp  = (prod2_r + fdlm_pkg::FBP_W'(fdlm_pkg::FB_ROUND)) >>> fdlm_pkg::FB_SHIFT;
    sum2 = fdlm_pkg::WIDE_W'(x2_r) + fdlm_pkg::WIDE_W'(fbp);
    new2 = fdlm_pkg::sat_smp(sum2);
    dly2 = (v3_r && (wpos3_r == pos2_r)) ? new3_r : dly2_r;
    dp_wr.we   = v2_r;
    dp_wr.addr = wpos2_r;
    dp_wr.data = new2;
  end

  // stage 3: mix products; a single-slot line reads back its own write
  always_comb begin
    wet3  = same3_r ? new3_r : dly3_r;
    dry_w = fdlm_pkg::MIX_ONE - coef.mix;
    pa3   = $signed({1'b0, dry_w}) * fdlm_pkg::MIXP_W'(x3_r);
    pb3   = $signed({1'b0, coef.mix}) * fdlm_pkg::MIXP_W'(wet3);
  end

  // stage 4: sum, round, saturate
  always_comb begin
    acc4 = (fdlm_pkg::WIDE_W'(pa4_r) + fdlm_pkg::WIDE_W'(pb4_r)
            + fdlm_pkg::WIDE_W'(fdlm_pkg::MIX_ROUND)) >>> fdlm_pkg::MIX_SHIFT;
    push_valid = v4_r;
    push_data  = fdlm_pkg::sat_smp(acc4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    wpos1_r <= issue.wpos;
    pos1_r  <= issue.pos;
    same1_r <= issue.same;
    x1_r    <= issue.x;

    wpos2_r <= wpos1_r;
    pos2_r  <= pos1_r;
    same2_r <= same1_r;
    x2_r    <= x1_r;
    prod2_r <= prod1;
    dly2_r  <= dly1;

    wpos3_r <= wpos2_r;
    same3_r <= same2_r;
    x3_r    <= x2_r;
    new3_r  <= new2;
    dly3_r  <= dly2;

    pa4_r   <= pa3;
    pb4_r   <= pb3;
  end

endmodule

FILE: hw/rtl/fdlm_outq.sv
// Output queue with credit count: holds finished items while the receiver
// stalls and limits accepted items to its depth. Depends on fdlm_pkg.

module fdlm_outq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_valid,
  input  fdlm_pkg::smp_t            push_data,
  input  logic                      in_accept,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [fdlm_pkg::SMP_W-1:0] out_tdata,
  output logic                      has_space
);

  fdlm_pkg::smp_t                  q_mem [fdlm_pkg::OQ_DEPTH];
  logic [fdlm_pkg::OQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [fdlm_pkg::OQ_CNT_W-1:0]   cnt_r, cnt_nxt, occ_r, occ_nxt;
  logic                            pop;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = q_mem[rd_ptr_r];
  assign pop        = out_tvalid && out_tready;
  assign has_space  = (occ_r < fdlm_pkg::OQ_CNT_W'(fdlm_pkg::OQ_DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + fdlm_pkg::OQ_PTR_W'(push_valid);
    rd_ptr_nxt = rd_ptr_r + fdlm_pkg::OQ_PTR_W'(pop);
    cnt_nxt    = cnt_r + fdlm_pkg::OQ_CNT_W'(push_valid) - fdlm_pkg::OQ_CNT_W'(pop);
    occ_nxt    = occ_r + fdlm_pkg::OQ_CNT_W'(in_accept) - fdlm_pkg::OQ_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      occ_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      occ_r    <= occ_nxt;
    end
  end

endmodule

FILE: hw/rtl/feedback_delay_line_mix_unit.sv
// Feedback comb delay line with dry/wet mix, one 24-bit audio sample per item.
// Input stream in_*, result stream out_*, register writes on cfg_*:
//   index 0 feedback gain (signed Q1.15), 1 mix amount (Q1.16, 65536 fully
//   wet, larger values held at 65536), 2 delay length (0 taken as 1, values
//   above 16384 held at 16384).
// Throughput is one item per cycle except during the clearing pass, a length
// change or a full output queue, set by the store's one write and two read
// ports per cycle; with a delay length of 1 the feedback add closes on itself
// and the block does not accept items back to back. An accepted item passes the
// datapath stage registers and the output queue before out_tvalid. After reset
// a clearing pass writes zero to all 16384 store entries, one per cycle;
// in_tready stays low until the pass ends. Register writes are taken meanwhile.
// A delay length write reduces the ring position modulo the new length;
// in_tready and cfg_ready stay low meanwhile.
// An 8-entry output queue holds results while out_tready is low; input keeps
// flowing until 8 items are outstanding.
// Depends on fdlm_pkg, fdlm_ram, fdlm_ctrl, fdlm_dpath, fdlm_outq.

module feedback_delay_line_mix_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fdlm_pkg::SMP_W-1:0]         in_tdata,   // [23:0] in_sample
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fdlm_pkg::SMP_W-1:0]         out_tdata,  // [23:0] out_sample
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fdlm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fdlm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic              in_accept;
  logic              issue_ready;
  logic              has_space;
  logic              push_valid;
  fdlm_pkg::smp_t    push_data;
  fdlm_pkg::issue_t  issue;
  fdlm_pkg::coef_t   coef;
  fdlm_pkg::ram_wr_t clr_wr, dp_wr, ram_wr;
  fdlm_pkg::smp_t    rd_w, rd_p;

  assign in_tready = issue_ready && has_space;
  assign in_accept = in_tvalid && in_tready;

  // clearing pass and live items never overlap
  always_comb begin
    ram_wr = clr_wr.we ? clr_wr : dp_wr;
  end

  fdlm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_accept   (in_accept),
    .in_sample   (in_tdata),
    .issue_ready (issue_ready),
    .issue       (issue),
    .coef        (coef),
    .clr_wr      (clr_wr)
  );

  fdlm_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .raddr_a (issue.wpos),
    .raddr_b (issue.pos),
    .rdata_a (rd_w),
    .rdata_b (rd_p)
  );

  fdlm_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .coef       (coef),
    .rd_w       (rd_w),
    .rd_p       (rd_p),
    .dp_wr      (dp_wr),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  fdlm_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .in_accept  (in_accept),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .has_space  (has_space)
  );

endmodule
